### src/stw_pkg.sv
// shared types, constants and tables for the scan to world point transform
// no dependencies
`default_nettype none
package stw_pkg;

	localparam int RANGE_BITS = 24;
	localparam int COORD_BITS = 32;

	localparam int ANGLE_W = 32;
	localparam int QUAT_W  = 16;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam int ROT_W  = 18;
	localparam int SQ_W   = 32;
	localparam int NUM_W  = 34;
	localparam int NRM_W  = 33;
	localparam int QUO_W  = 17;
	localparam int DIV_W  = NRM_W + QUO_W;
	localparam int B_W    = 33;
	localparam int CRD_W  = 34;
	localparam int P_W    = RANGE_BITS + 10;
	localparam int MA_W   = (P_W > CRD_W) ? P_W : CRD_W;
	localparam int MB_W   = RANGE_BITS + 1;
	localparam int M_W    = MA_W + MB_W;
	localparam int ACC_B  = ((P_W + ROT_W) > (POS_W + 24)) ? (P_W + ROT_W) : (POS_W + 24);
	localparam int ACC_W  = ACC_B + 2;
	localparam int CORDIC_ITERS = 28;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd3;

	localparam logic signed [B_W-1:0] PI_Q28        = 33'sd843314857;
	localparam logic signed [B_W-1:0] TWO_PI_Q28    = 33'sd1686629714;
	localparam logic signed [B_W-1:0] HALF_PI_Q28   = 33'sd421657428;
	localparam logic signed [B_W-1:0] MOUNT_YAW_Q28 = 33'sd393546933;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [P_W-1:0] MOUNT_X_Q24 = P_W'(671089);
	localparam logic signed [P_W-1:0] MOUNT_Z_Q24 = P_W'(2516583);
	localparam logic signed [ROT_W-1:0] ONE_Q16 = 18'sd65536;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_NORM, OP_DIVI, OP_DIVS, OP_DIVW, OP_TRANS,
		OP_ANGLE, OP_REDUCE, OP_CORDIC, OP_POLAR, OP_MAC, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] idx;
		logic [3:0] ent;
		logic [1:0] row;
		logic [1:0] col;
		logic       issue;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic in_range;
		logic reduce_done;
	} dp_sts_t;

	function automatic logic [B_W-1:0] atan_q28(input logic [4:0] i);
		case (i)
			5'd0: atan_q28 = 33'd210828714;
			5'd1: atan_q28 = 33'd124459457;
			5'd2: atan_q28 = 33'd65760959;
			5'd3: atan_q28 = 33'd33381290;
			5'd4: atan_q28 = 33'd16755422;
			5'd5: atan_q28 = 33'd8385879;
			5'd6: atan_q28 = 33'd4193963;
			5'd7: atan_q28 = 33'd2097109;
			5'd8: atan_q28 = 33'd1048571;
			5'd9: atan_q28 = 33'd524287;
			default: atan_q28 = B_W'(33'd1) << (5'd28 - i);
		endcase
	endfunction

	// operand pair for the quaternion products: w=0 x=1 y=2 z=3
	function automatic logic [3:0] sq_pair(input logic [4:0] k);
		case (k)
			5'd0: sq_pair = {2'd0, 2'd0};
			5'd1: sq_pair = {2'd1, 2'd1};
			5'd2: sq_pair = {2'd2, 2'd2};
			5'd3: sq_pair = {2'd3, 2'd3};
			5'd4: sq_pair = {2'd1, 2'd2};
			5'd5: sq_pair = {2'd0, 2'd3};
			5'd6: sq_pair = {2'd1, 2'd3};
			5'd7: sq_pair = {2'd0, 2'd2};
			5'd8: sq_pair = {2'd2, 2'd3};
			5'd9: sq_pair = {2'd0, 2'd1};
			default: sq_pair = 4'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

### src/stw_ctrl.sv
// sequencing state machine for pose and sample beats
// depends on stw_pkg
`default_nettype none
module stw_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            action,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire stw_pkg::dp_sts_t sts,
	output stw_pkg::dp_cmd_t     cmd
);
	import stw_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_SQ     = 13'b0000000000010,
		S_NORM   = 13'b0000000000100,
		S_DIVI   = 13'b0000000001000,
		S_DIVS   = 13'b0000000010000,
		S_DIVW   = 13'b0000000100000,
		S_TRANS  = 13'b0000001000000,
		S_ANGLE  = 13'b0000010000000,
		S_REDUCE = 13'b0000100000000,
		S_CORDIC = 13'b0001000000000,
		S_POLAR  = 13'b0010000000000,
		S_MAC    = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	state_t     state_q;
	logic [4:0] idx_q;
	logic [3:0] ent_q;
	logic [1:0] row_q;
	logic [1:0] col_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.idx   = idx_q;
		cmd.ent   = ent_q;
		cmd.row   = row_q;
		cmd.col   = col_q;
		cmd.issue = (idx_q < 5'd9);
		case (state_q)
			S_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
			S_SQ:     cmd.op = OP_SQ;
			S_NORM:   cmd.op = OP_NORM;
			S_DIVI:   cmd.op = OP_DIVI;
			S_DIVS:   cmd.op = OP_DIVS;
			S_DIVW:   cmd.op = OP_DIVW;
			S_TRANS:  cmd.op = OP_TRANS;
			S_ANGLE:  cmd.op = OP_ANGLE;
			S_REDUCE: cmd.op = OP_REDUCE;
			S_CORDIC: cmd.op = OP_CORDIC;
			S_POLAR:  cmd.op = OP_POLAR;
			S_MAC:    cmd.op = OP_MAC;
			S_OUT:    cmd.op = slot_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			ent_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept)
						state_q <= action ? S_SQ : S_ANGLE;
				end
				S_SQ: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'd9)
						state_q <= S_NORM;
				end
				S_NORM: begin
					ent_q   <= '0;
					state_q <= S_DIVI;
				end
				S_DIVI: begin
					idx_q   <= '0;
					state_q <= sts.n_zero ? S_IDLE : S_DIVS;
				end
				S_DIVS: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'd16)
						state_q <= S_DIVW;
				end
				S_DIVW: begin
					ent_q <= ent_q + 4'd1;
					state_q <= (ent_q == 4'd8) ? S_TRANS : S_DIVI;
				end
				S_TRANS: state_q <= S_IDLE;
				S_ANGLE: state_q <= sts.in_range ? S_REDUCE : S_IDLE;
				S_REDUCE: begin
					idx_q <= '0;
					if (sts.reduce_done)
						state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'(CORDIC_ITERS - 1)) begin
						idx_q   <= '0;
						state_q <= S_POLAR;
					end
				end
				S_POLAR: begin
					idx_q <= idx_q + 5'd1;
					row_q <= '0;
					col_q <= '0;
					if (idx_q == 5'd2) begin
						idx_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					idx_q <= idx_q + 5'd1;
					if (col_q == 2'd2) begin
						col_q <= '0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
					if (idx_q == 5'd9)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/stw_datapath.sv
// datapath: config registers, pose store, divider, cordic, shared multiplier, accumulators
// depends on stw_pkg
`default_nettype none
module stw_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire stw_pkg::dp_cmd_t                      cmd,
	output stw_pkg::dp_sts_t                           sts,
	input  wire logic                                  cfg_we,
	input  wire logic [stw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [stw_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic [stw_pkg::RANGE_BITS-1:0]        range,
	input  wire logic                                  first_sample,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_x,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_y,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_z,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_w,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_x,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_y,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_z,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_x,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_y,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_z
);
	import stw_pkg::*;

	logic [RANGE_BITS-1:0] lower_q, upper_q;
	logic [ANGLE_W-1:0]    start_q, step_q, cur_q;
	logic signed [ROT_W-1:0] rot_q [9];
	logic signed [POS_W-1:0] trans_q [3];

	logic [RANGE_BITS-1:0]   range_q;
	logic                    first_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic signed [QUAT_W-1:0] quat_q [4];

	logic signed [SQ_W-1:0] prod_q [10];
	logic [NRM_W-1:0]       n_q;
	logic [NRM_W-1:0]       rem_q;
	logic [QUO_W-1:0]       dsh_q;
	logic [QUO_W-1:0]       quo_q;
	logic                   neg_q;

	logic signed [B_W-1:0]   b_q;
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic                    flip_q;

	logic signed [M_W-1:0]   mul_q;
	logic signed [P_W-1:0]   p_q [3];
	logic signed [ACC_W-1:0] acc_q [3];
	logic [1:0]              mrow_s1;
	logic                    mvalid_s1;

	logic signed [NUM_W-1:0] pe [10];
	logic signed [NUM_W-1:0] num;
	logic [NRM_W-1:0]        mag;
	logic [DIV_W-1:0]        dvd;
	logic [NRM_W+1:0]        trial;
	logic [3:0]              pair;
	logic signed [MA_W-1:0]  ma;
	logic signed [MB_W-1:0]  mb;
	logic signed [M_W-1:0]   prod;
	logic signed [CRD_W-1:0] cos_v, sin_v, dx, dy;
	logic signed [M_W-1:0]   rsum;
	logic signed [P_W-1:0]   rnd22;
	logic [ANGLE_W-1:0]      ang;
	logic [3:0]              ridx;
	logic signed [ACC_W-1:0] osum [3];
	logic signed [ACC_W-1:0] ornd [3];
	logic signed [COORD_BITS-1:0] osat [3];
	logic signed [COORD_BITS-1:0] out_q [3];

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	always_comb begin
		for (int k = 0; k < 10; k++)
			pe[k] = NUM_W'(prod_q[k]);
		case (cmd.ent)
			4'd0: num = pe[0] + pe[1] - pe[2] - pe[3];
			4'd1: num = (pe[4] - pe[5]) <<< 1;
			4'd2: num = (pe[6] + pe[7]) <<< 1;
			4'd3: num = (pe[4] + pe[5]) <<< 1;
			4'd4: num = pe[0] - pe[1] + pe[2] - pe[3];
			4'd5: num = (pe[8] - pe[9]) <<< 1;
			4'd6: num = (pe[6] - pe[7]) <<< 1;
			4'd7: num = (pe[8] + pe[9]) <<< 1;
			4'd8: num = pe[0] - pe[1] - pe[2] + pe[3];
			default: num = '0;
		endcase
		mag   = num[NUM_W-1] ? NRM_W'(-num) : NRM_W'(num);
		dvd   = {1'b0, mag, {(QUO_W-1){1'b0}}} + DIV_W'(n_q >> 1);
		trial = {1'b0, rem_q, dsh_q[QUO_W-1]} - {2'b00, n_q};
	end

	always_comb begin
		cos_v = flip_q ? -cx_q : cx_q;
		sin_v = flip_q ? -cy_q : cy_q;
		dx    = cy_q >>> cmd.idx;
		dy    = cx_q >>> cmd.idx;
		pair  = sq_pair(cmd.idx);
		ridx  = {cmd.row, 1'b0} + {2'b00, cmd.row} + {2'b00, cmd.col};
		case (cmd.op)
			OP_SQ: begin
				ma = MA_W'(quat_q[pair[3:2]]);
				mb = MB_W'(quat_q[pair[1:0]]);
			end
			OP_POLAR: begin
				ma = (cmd.idx == 5'd0) ? MA_W'(cos_v) : MA_W'(sin_v);
				mb = $signed({1'b0, range_q});
			end
			OP_MAC: begin
				ma = MA_W'(p_q[cmd.col]);
				mb = MB_W'(rot_q[ridx]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod  = ma * mb;
		rsum  = mul_q + (M_W'(1) <<< 21);
		rnd22 = P_W'(rsum >>> 22);
		ang   = first_q ? start_q : cur_q;
		for (int i = 0; i < 3; i++) begin
			osum[i] = acc_q[i] + (ACC_W'(1) <<< 23);
			ornd[i] = osum[i] >>> 24;
			if (ornd[i] > SAT_HI)
				osat[i] = COORD_BITS'(SAT_HI);
			else if (ornd[i] < SAT_LO)
				osat[i] = COORD_BITS'(SAT_LO);
			else
				osat[i] = COORD_BITS'(ornd[i]);
		end
	end

	assign sts.n_zero      = (n_q == '0);
	assign sts.in_range    = (range_q >= lower_q) && (range_q <= upper_q);
	assign sts.reduce_done = (b_q <= PI_Q28) && (b_q >= -PI_Q28);

	assign point_x = out_q[0];
	assign point_y = out_q[1];
	assign point_z = out_q[2];

	// state with defined reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '1;
			start_q <= '0;
			step_q  <= '0;
			cur_q   <= '0;
			for (int i = 0; i < 9; i++)
				rot_q[i] <= (i % 4 == 0) ? ONE_Q16 : '0;
			for (int i = 0; i < 3; i++)
				trans_q[i] <= '0;
			mvalid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_LOWER: lower_q <= cfg_data[RANGE_BITS-1:0];
					REG_RANGE_UPPER: upper_q <= cfg_data[RANGE_BITS-1:0];
					REG_ANGLE_START: start_q <= cfg_data[ANGLE_W-1:0];
					REG_ANGLE_STEP:  step_q  <= cfg_data[ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_ANGLE)
				cur_q <= ang + step_q;
			if (cmd.op == OP_DIVW)
				rot_q[cmd.ent] <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			if (cmd.op == OP_TRANS)
				for (int i = 0; i < 3; i++)
					trans_q[i] <= pos_q[i];
			mvalid_s1 <= (cmd.op == OP_MAC) && cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				range_q   <= range;
				first_q   <= first_sample;
				pos_q[0]  <= pos_x;
				pos_q[1]  <= pos_y;
				pos_q[2]  <= pos_z;
				quat_q[0] <= quat_w;
				quat_q[1] <= quat_x;
				quat_q[2] <= quat_y;
				quat_q[3] <= quat_z;
			end
			OP_SQ: prod_q[cmd.idx[3:0]] <= SQ_W'(prod);
			OP_NORM: n_q <= NRM_W'(prod_q[0]) + NRM_W'(prod_q[1]) + NRM_W'(prod_q[2])
				+ NRM_W'(prod_q[3]);
			OP_DIVI: begin
				rem_q <= dvd[DIV_W-1:QUO_W];
				dsh_q <= dvd[QUO_W-1:0];
				neg_q <= num[NUM_W-1];
				quo_q <= '0;
			end
			OP_DIVS: begin
				if (!trial[NRM_W+1]) begin
					rem_q <= trial[NRM_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NRM_W-2:0], dsh_q[QUO_W-1]};
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q << 1;
			end
			OP_ANGLE: b_q <= B_W'($signed(ang)) - MOUNT_YAW_Q28;
			OP_REDUCE: begin
				if (b_q > PI_Q28) begin
					b_q <= b_q - TWO_PI_Q28;
				end else if (b_q < -PI_Q28) begin
					b_q <= b_q + TWO_PI_Q28;
				end else begin
					cx_q <= CORDIC_GAIN_Q30;
					cy_q <= '0;
					if (b_q > HALF_PI_Q28) begin
						b_q    <= b_q - PI_Q28;
						flip_q <= 1'b1;
					end else if (b_q < -HALF_PI_Q28) begin
						b_q    <= b_q + PI_Q28;
						flip_q <= 1'b1;
					end else begin
						flip_q <= 1'b0;
					end
				end
			end
			OP_CORDIC: begin
				if (!b_q[B_W-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					b_q  <= b_q - $signed(atan_q28(cmd.idx));
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					b_q  <= b_q + $signed(atan_q28(cmd.idx));
				end
			end
			OP_POLAR: begin
				mul_q <= prod;
				if (cmd.idx == 5'd1)
					p_q[0] <= rnd22 + MOUNT_X_Q24;
				if (cmd.idx == 5'd2) begin
					p_q[1] <= -rnd22;
					p_q[2] <= MOUNT_Z_Q24;
					for (int i = 0; i < 3; i++)
						acc_q[i] <= ACC_W'(trans_q[i]) <<< 24;
				end
			end
			OP_MAC: begin
				mul_q   <= prod;
				mrow_s1 <= cmd.row;
			end
			OP_OUT: begin
				for (int i = 0; i < 3; i++)
					out_q[i] <= osat[i];
			end
			default: ;
		endcase
		if (mvalid_s1)
			acc_q[mrow_s1] <= acc_q[mrow_s1] + ACC_W'(mul_q);
	end

endmodule
`default_nettype wire

### src/scan_to_world_point_transform_unit.sv
// top level: lidar range samples to world points through mount and stored pose
// depends on stw_pkg, stw_ctrl, stw_datapath
// sample beat: the 28 cordic steps dominate it; a sample out of limits gives no point
// pose beat: nine 17-step quotient divisions, none for a zero quaternion
// one beat in work at a time, next accept the cycle after it ends; a stalled point holds the block
// reset: asynchronous, pose identity, angle and config registers at reset values
`default_nettype none
module scan_to_world_point_transform_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [stw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [stw_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  action,
	input  wire logic [stw_pkg::RANGE_BITS-1:0]        range,
	input  wire logic                                  first_sample,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_x,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_y,
	input  wire logic signed [stw_pkg::POS_W-1:0]      pos_z,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_w,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_x,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_y,
	input  wire logic signed [stw_pkg::QUAT_W-1:0]     quat_z,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_x,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_y,
	output logic signed [stw_pkg::COORD_BITS-1:0]      point_z
);
	import stw_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	stw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stw_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.range        (range),
		.first_sample (first_sample),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z)
	);

endmodule
`default_nettype wire
